FILE: design/pis_pkg.sv
// Package for the particle integrator step core: types, codes and constants.
// No dependencies.
`timescale 1ns / 1ps
package pis_pkg;
	localparam int CompW = 32;

	typedef enum logic [1:0] {
		REQ_LOAD = 2'd0,
		REQ_SETPOS = 2'd1,
		REQ_STEP = 2'd2,
		REQ_NONE = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		METH_EULER = 2'd0,
		METH_RK2 = 2'd1,
		METH_VERLET = 2'd2,
		METH_OFF = 2'd3
	} meth_t;

	typedef enum logic [2:0] {
		CFG_INV_MASS = 3'd0,
		CFG_GRAV_X = 3'd1,
		CFG_GRAV_Y = 3'd2,
		CFG_GRAV_Z = 3'd3,
		CFG_DT = 3'd4,
		CFG_METHOD = 3'd5
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_READ, ST_ACC, ST_MUL1, ST_MUL2, ST_DIV, ST_OUT
	} state_t;

	typedef logic signed [CompW-1:0] comp_t;
	typedef comp_t [2:0] vec_t;

	// Floor of v / 2^k for k given; arithmetic shift rounds toward minus infinity.
	function automatic logic signed [79:0] fshr(input logic signed [79:0] v, input int k);
		fshr = v >>> k;
	endfunction

	// Clamp a wide value to 32 bits, flagging a hit.
	function automatic comp_t sat32(input logic signed [79:0] v, output logic hit);
		logic signed [79:0] hi;
		logic signed [79:0] lo;
		hi = 80'sd2147483647;
		lo = -80'sd2147483648;
		hit = 1'b0;
		sat32 = v[CompW-1:0];
		if (v > hi) begin
			hit = 1'b1;
			sat32 = comp_t'(32'h7fffffff);
		end else if (v < lo) begin
			hit = 1'b1;
			sat32 = comp_t'(32'h80000000);
		end
	endfunction
endpackage

FILE: design/pis_div.sv
// Iterative signed divider, one quotient bit per cycle, truncation toward zero.
// Depends on pis_pkg.
`timescale 1ns / 1ps
module pis_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [63:0] num,
	input logic [16:0] den,
	output logic busy,
	output logic signed [63:0] quot
);
	import pis_pkg::*;

	logic [63:0] rem_q;
	logic [63:0] qbits_q;
	logic [63:0] mag_q;
	logic neg_q;
	logic [6:0] cnt_q;
	logic [16:0] den_q;
	logic [64:0] trial;

	assign busy = (cnt_q != 7'd0);
	assign trial = {rem_q, mag_q[63]} - {48'd0, den_q};
	assign quot = neg_q ? -$signed(qbits_q) : $signed(qbits_q);

	// restoring division, one bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 7'd0;
		end else if (start) begin
			cnt_q <= 7'd64;
		end else if (cnt_q != 7'd0) begin
			cnt_q <= cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= 64'd0;
			qbits_q <= 64'd0;
			mag_q <= num[63] ? 64'(-num) : 64'(num);
			neg_q <= num[63];
			den_q <= den;
		end else if (cnt_q != 7'd0) begin
			mag_q <= {mag_q[62:0], 1'b0};
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				qbits_q <= {qbits_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[62:0], mag_q[63]};
				qbits_q <= {qbits_q[62:0], 1'b0};
			end
		end
	end
endmodule

FILE: design/pis_store.sv
// Node state memory: position, previous position and velocity, one row per node.
// Synchronous, registered read. Depends on pis_pkg.
`timescale 1ns / 1ps
module pis_store #(
	parameter int Depth = 1024,
	parameter int AW = 10
) (
	input logic clk,
	input logic [AW-1:0] rd_addr,
	output pis_pkg::vec_t rd_pos,
	output pis_pkg::vec_t rd_prev,
	output pis_pkg::vec_t rd_vel,
	input logic wr_en,
	input logic [AW-1:0] wr_addr,
	input pis_pkg::vec_t wr_pos,
	input pis_pkg::vec_t wr_prev,
	input pis_pkg::vec_t wr_vel
);
	import pis_pkg::*;

	vec_t pos_mem [Depth];
	vec_t prev_mem [Depth];
	vec_t vel_mem [Depth];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			pos_mem[wr_addr] <= wr_pos;
			prev_mem[wr_addr] <= wr_prev;
			vel_mem[wr_addr] <= wr_vel;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_pos <= pos_mem[rd_addr];
		rd_prev <= prev_mem[rd_addr];
		rd_vel <= vel_mem[rd_addr];
	end
endmodule

FILE: design/particle_integrator_step_core.sv
// Particle integrator step core: per-node read, integrate, write back.
// Path: READ, ACC, then OUT for loads, set-position and no-op requests; Euler and RK2
// steps add MUL1, MUL2; nonzero-step Verlet also adds DIV (three serial divides).
// One item in flight; next request can be taken in the cycle after the result is accepted.
// Reset: registers to defaults, then a velocity clearing pass over all NODE_COUNT nodes.
// Depends on pis_pkg, pis_store, pis_div.
`timescale 1ns / 1ps
module particle_integrator_step_core #(
	parameter int NODE_COUNT = 1024
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [31:0] cfg_data,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// node_index[9:0], value_x[41:10], value_y[73:42], value_z[105:74], pad
	input logic [111:0] s_axis_tdata,
	// req_type[1:0]
	input logic [1:0] s_axis_tuser,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// node_out[9:0], pos_x..pos_z, vel_x..vel_z [201:10], saturated[202], pad
	output logic [207:0] m_axis_tdata
);
	import pis_pkg::*;

	localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

	// configuration registers
	logic [30:0] inv_mass_q;
	vec_t grav_q;
	logic [15:0] dt_q;
	logic [1:0] method_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_mass_q <= 31'd6553600;
			grav_q <= '0;
			dt_q <= 16'd655;
			method_q <= METH_EULER;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_INV_MASS: inv_mass_q <= cfg_data[30:0];
				CFG_GRAV_X: grav_q[0] <= cfg_data;
				CFG_GRAV_Y: grav_q[1] <= cfg_data;
				CFG_GRAV_Z: grav_q[2] <= cfg_data;
				CFG_DT: dt_q <= cfg_data[15:0];
				CFG_METHOD: method_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// request capture
	logic [1:0] kind_q;
	logic [9:0] node_q;
	vec_t val_q;
	logic in_range_q;

	state_t state_q, state_d;
	logic [AW:0] clr_q;
	logic clearing;
	assign clearing = (clr_q != (AW+1)'(NODE_COUNT));

	vec_t rd_pos, rd_prev, rd_vel;
	logic wr_en;
	logic [AW-1:0] wr_addr;
	vec_t wr_pos, wr_prev, wr_vel;
	logic [AW-1:0] rd_addr;

	assign rd_addr = AW'(node_q);

	pis_store #(.Depth(NODE_COUNT), .AW(AW)) u_store (
		.clk(clk), .rd_addr(rd_addr), .rd_pos(rd_pos), .rd_prev(rd_prev),
		.rd_vel(rd_vel), .wr_en(wr_en), .wr_addr(wr_addr), .wr_pos(wr_pos),
		.wr_prev(wr_prev), .wr_vel(wr_vel)
	);

	// working registers
	vec_t pos_q, prev_q, vel_q, acc_q, npos_q, nvel_q;
	logic signed [63:0] p1_q [3];
	logic signed [63:0] p2_q [3];
	logic hit_q;
	logic [1:0] ax_q;
	logic active;
	assign active = (kind_q == REQ_STEP) && (method_q != METH_OFF) && in_range_q;

	logic div_start;
	logic div_busy;
	logic signed [63:0] div_num;
	logic signed [63:0] div_quot;

	pis_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den({dt_q, 1'b0}), .busy(div_busy), .quot(div_quot)
	);

	logic div_wait_q;
	logic wb_done_q;
	assign div_num = 64'((64'(signed'(npos_q[ax_q])) - 64'(signed'(pos_q[ax_q]))) <<< 16);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (s_axis_tvalid && s_axis_tready) state_d = ST_READ;
			ST_READ: state_d = ST_ACC;
			ST_ACC: state_d = active ? ST_MUL1 : ST_OUT;
			ST_MUL1: state_d = ST_MUL2;
			ST_MUL2: state_d = (method_q == METH_VERLET && dt_q != 16'd0) ? ST_DIV : ST_OUT;
			ST_DIV: if (div_wait_q && !div_busy && ax_q == 2'd2) state_d = ST_OUT;
			ST_OUT: if (m_axis_tready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_axis_tready = (state_q == ST_IDLE) && !clearing;
		m_axis_tvalid = (state_q == ST_OUT);
		div_start = (state_q == ST_DIV) && !div_wait_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			clr_q <= '0;
			div_wait_q <= 1'b0;
			ax_q <= 2'd0;
			wb_done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			wb_done_q <= (state_q == ST_OUT);
			if (clearing) clr_q <= clr_q + 1'b1;
			if (state_q == ST_DIV) begin
				if (!div_wait_q) begin
					div_wait_q <= 1'b1;
				end else if (!div_busy) begin
					div_wait_q <= 1'b0;
					ax_q <= ax_q + 2'd1;
				end
			end else begin
				ax_q <= 2'd0;
				div_wait_q <= 1'b0;
			end
		end
	end

	// datapath
	logic signed [79:0] wide [3];
	logic h [3];
	comp_t a_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			wide[i] = fshr(80'(signed'(val_q[i])) * 80'(signed'({1'b0, inv_mass_q})), 16)
				+ 80'(signed'(grav_q[i]));
			a_c[i] = sat32(wide[i], h[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			kind_q <= s_axis_tuser;
			node_q <= s_axis_tdata[9:0];
			in_range_q <= ({22'd0, s_axis_tdata[9:0]} < NODE_COUNT);
			val_q[0] <= s_axis_tdata[41:10];
			val_q[1] <= s_axis_tdata[73:42];
			val_q[2] <= s_axis_tdata[105:74];
		end
		case (state_q)
			ST_ACC: begin
				pos_q <= rd_pos;
				prev_q <= rd_prev;
				vel_q <= rd_vel;
				nvel_q <= rd_vel;
				if (kind_q == REQ_LOAD || kind_q == REQ_SETPOS) begin
					npos_q <= val_q;
				end else begin
					npos_q <= rd_pos;
				end
				if (active) begin
					acc_q <= {a_c[2], a_c[1], a_c[0]};
					hit_q <= h[0] | h[1] | h[2];
				end else begin
					hit_q <= 1'b0;
				end
			end
			ST_MUL1: begin
				for (int i = 0; i < 3; i++) begin
					p1_q[i] <= 64'(signed'(acc_q[i])) * 64'(signed'({1'b0, dt_q}));
					p2_q[i] <= 64'(signed'(vel_q[i])) * 64'(signed'({1'b0, dt_q}));
				end
			end
			ST_MUL2: begin
				logic signed [79:0] t;
				logic signed [79:0] dd;
				logic hh;
				logic acc_hit;
				comp_t nv;
				acc_hit = 1'b0;
				for (int i = 0; i < 3; i++) begin
					dd = 80'(p1_q[i]) * 80'(signed'({1'b0, dt_q}));
					case (meth_t'(method_q))
						METH_EULER: begin
							npos_q[i] <= sat32(80'(signed'(pos_q[i])) + fshr(80'(p2_q[i]), 16), hh);
							acc_hit = acc_hit | hh;
							nvel_q[i] <= sat32(80'(signed'(vel_q[i])) + fshr(80'(p1_q[i]), 16), hh);
							acc_hit = acc_hit | hh;
						end
						METH_RK2: begin
							nv = sat32(80'(signed'(vel_q[i])) + fshr(80'(p1_q[i]), 16), hh);
							acc_hit = acc_hit | hh;
							nvel_q[i] <= nv;
							t = 80'(signed'(pos_q[i]))
								+ fshr(80'(signed'(nv)) * 80'(signed'({1'b0, dt_q})), 16)
								+ fshr(dd, 33);
							npos_q[i] <= sat32(t, hh);
							acc_hit = acc_hit | hh;
						end
						default: begin
							t = 80'(signed'(pos_q[i])) * 80'sd2 - 80'(signed'(prev_q[i]))
								+ fshr(dd, 32);
							npos_q[i] <= sat32(t, hh);
							acc_hit = acc_hit | hh;
							nvel_q[i] <= '0;
						end
					endcase
				end
				hit_q <= hit_q | acc_hit;
			end
			ST_DIV: begin
				logic hd;
				if (div_wait_q && !div_busy) begin
					nvel_q[ax_q] <= sat32(80'(div_quot), hd);
					hit_q <= hit_q | hd;
				end
			end
			default: ;
		endcase
	end

	// write back in the first output cycle; clearing pass zeroes velocity
	always_comb begin
		wr_en = 1'b0;
		wr_addr = AW'(node_q);
		wr_pos = npos_q;
		wr_prev = (kind_q == REQ_LOAD) ? val_q : (active ? pos_q : prev_q);
		wr_vel = nvel_q;
		if (clearing) begin
			wr_en = 1'b1;
			wr_addr = clr_q[AW-1:0];
			wr_vel = '0;
		end else if (state_q == ST_OUT && !wb_done_q) begin
			wr_en = in_range_q && (kind_q != REQ_NONE) && (kind_q != REQ_STEP || active);
		end
	end

	always_comb begin
		m_axis_tdata = '0;
		m_axis_tdata[9:0] = node_q;
		if (in_range_q) begin
			m_axis_tdata[41:10] = npos_q[0];
			m_axis_tdata[73:42] = npos_q[1];
			m_axis_tdata[105:74] = npos_q[2];
			m_axis_tdata[137:106] = nvel_q[0];
			m_axis_tdata[169:138] = nvel_q[1];
			m_axis_tdata[201:170] = nvel_q[2];
			m_axis_tdata[202] = hit_q & active;
		end
	end

`ifndef SYNTH
	a_no_take_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while an item is in flight");
	a_no_take_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !s_axis_tready)
		else $error("input taken during clearing pass");
	a_div_only_verlet: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> method_q == METH_VERLET)
		else $error("divider started outside Verlet");
`endif
endmodule
